@@ rtl/core/irtx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irtx_pkg
// Shared types, widths and helpers of the infrared frame transmitter.
// ----------------------------------------------------------------------------
package irtx_pkg;

  localparam int FRAME_BITS  = 20;
  localparam int CODE_W      = 20;
  localparam int HALF_W      = 8;
  localparam int MARK_W      = 12;
  localparam int PER_W       = HALF_W + 1;
  localparam int REM_W       = PER_W + 1;
  localparam int TOT_W       = 13;
  localparam int BITS_LEFT_W = 5;
  localparam int STEP_W      = $clog2(MARK_W + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int NUM_LANES   = 3;

  localparam int LANE_HDR  = 0;
  localparam int LANE_ZERO = 1;
  localparam int LANE_ONE  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MARK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MARK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MARK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE        = 3'd4;

  localparam logic [HALF_W-1:0] RST_CARRIER_HALF = 8'd12;
  localparam logic [MARK_W-1:0] RST_HEADER_MARK  = 12'd2400;
  localparam logic [MARK_W-1:0] RST_ZERO_MARK    = 12'd600;
  localparam logic [MARK_W-1:0] RST_ONE_MARK     = 12'd1200;
  localparam logic [MARK_W-1:0] RST_SPACE        = 12'd600;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SEND = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_HDR_MARK  = 5'b00010,
    PH_HDR_SPACE = 5'b00100,
    PH_BIT_MARK  = 5'b01000,
    PH_BIT_SPACE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [HALF_W-1:0] carrier_half_us;
    logic [MARK_W-1:0] header_mark_us;
    logic [MARK_W-1:0] zero_mark_us;
    logic [MARK_W-1:0] one_mark_us;
    logic [MARK_W-1:0] space_us;
  } cfg_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
  } result_t;

  typedef logic [NUM_LANES-1:0][TOT_W-1:0] burst_totals_t;

  function automatic logic [HALF_W-1:0] half_period(input logic [HALF_W-1:0] half);
    return (half == '0) ? HALF_W'(1) : half;
  endfunction

  function automatic logic [PER_W-1:0] carrier_period(input logic [HALF_W-1:0] half);
    return {half_period(half), 1'b0};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/irtx_burst_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irtx_burst_calc
// Burst length unit: takes each mark length to the next whole multiple of the
// carrier period above it, by a bit-serial remainder, three lanes in step.
// ----------------------------------------------------------------------------
module irtx_burst_calc (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  irtx_pkg::cfg_t         cfg,
  output logic                   busy,
  output irtx_pkg::burst_totals_t totals
);
  import irtx_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] bit_idx;
  logic [PER_W-1:0]  per;
  logic [MARK_W-1:0] len      [NUM_LANES];
  logic [REM_W-1:0]  rem      [NUM_LANES];
  logic [REM_W-1:0]  rem_next [NUM_LANES];
  logic [REM_W-1:0]  shifted  [NUM_LANES];

  assign per            = carrier_period(cfg.carrier_half_us);
  assign bit_idx        = STEP_W'(MARK_W - 1) - step;
  assign len[LANE_HDR]  = cfg.header_mark_us;
  assign len[LANE_ZERO] = cfg.zero_mark_us;
  assign len[LANE_ONE]  = cfg.one_mark_us;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      shifted[i]  = {rem[i][REM_W-2:0], len[i][bit_idx]};
      rem_next[i] = (shifted[i] >= REM_W'(per)) ? shifted[i] - REM_W'(per) : shifted[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      step <= '0;
      for (int i = 0; i < NUM_LANES; i++) rem[i] <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
      for (int i = 0; i < NUM_LANES; i++) rem[i] <= '0;
    end else if (busy) begin
      if (step == STEP_W'(MARK_W)) begin
        busy <= 1'b0;
        for (int i = 0; i < NUM_LANES; i++) begin
          totals[i] <= TOT_W'(len[i]) + TOT_W'(per) - TOT_W'(rem[i]);
        end
      end else begin
        step <= step + STEP_W'(1);
        for (int i = 0; i < NUM_LANES; i++) rem[i] <= rem_next[i];
      end
    end
  end

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> step <= STEP_W'(MARK_W))
    else $error("burst calc step counter overran");

endmodule
`default_nettype wire

@@ rtl/core/irtx_frame_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irtx_frame_engine
// Frame sequencer: header mark, header space, then one mark and space per
// code bit, carrier modulated; one word per microsecond tick or send.
// ----------------------------------------------------------------------------
module irtx_frame_engine (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     accept,
  input  wire                     action,
  input  wire [irtx_pkg::CODE_W-1:0] code_word,
  input  irtx_pkg::cfg_t          cfg,
  input  irtx_pkg::burst_totals_t totals,
  output irtx_pkg::result_t       res
);
  import irtx_pkg::*;

  phase_t                 phase, phase_next;
  logic [FRAME_BITS-1:0]  bit_shift, bit_shift_next;
  logic [BITS_LEFT_W-1:0] bits_left, bits_left_next;
  logic [TOT_W-1:0]       elapsed, elapsed_next;
  logic [PER_W-1:0]       carrier_pos, carrier_pos_next;

  logic [HALF_W-1:0] half;
  logic [PER_W-1:0]  per;
  logic [PER_W-1:0]  cp0;
  logic [PER_W-1:0]  cp1;
  logic [PER_W-1:0]  cp_inc;
  logic [TOT_W-1:0]  elapsed_inc;
  logic [TOT_W-1:0]  mark_total;
  logic              end_mark;
  logic              end_space;
  logic              space_zero;
  logic              to_bit_mark;
  logic              to_space;
  logic              bit_done;

  assign half        = half_period(cfg.carrier_half_us);
  assign per         = carrier_period(cfg.carrier_half_us);
  assign cp0         = (carrier_pos >= per) ? '0 : carrier_pos;
  assign cp1         = cp0 + PER_W'(1);
  assign cp_inc      = (cp1 >= per) ? '0 : cp1;
  assign elapsed_inc = elapsed + TOT_W'(1);
  assign space_zero  = (cfg.space_us == '0);
  assign mark_total  = (phase == PH_HDR_MARK) ? totals[LANE_HDR] :
                       bit_shift[FRAME_BITS-1] ? totals[LANE_ONE] : totals[LANE_ZERO];

  always_comb begin
    phase_next       = phase;
    bit_shift_next   = bit_shift;
    bits_left_next   = bits_left;
    elapsed_next     = elapsed;
    carrier_pos_next = carrier_pos;
    res              = '0;
    end_mark         = 1'b0;
    end_space        = 1'b0;
    to_bit_mark      = 1'b0;
    to_space         = 1'b0;
    bit_done         = 1'b0;
    if (accept) begin
      if (action == ACT_SEND) begin
        res.busy_res = 1'b1;
        if (phase == PH_IDLE) begin
          bit_shift_next   = FRAME_BITS'(code_word);
          bits_left_next   = BITS_LEFT_W'(FRAME_BITS - 1);
          phase_next       = PH_HDR_MARK;
          elapsed_next     = '0;
          carrier_pos_next = '0;
        end
      end else if (phase != PH_IDLE) begin
        res.busy_res = 1'b1;
        case (phase)
          PH_HDR_MARK, PH_BIT_MARK: begin
            res.ir_level     = (cp0 < PER_W'(half));
            carrier_pos_next = cp_inc;
            elapsed_next     = elapsed_inc;
            end_mark         = (elapsed_inc >= mark_total);
          end
          PH_HDR_SPACE, PH_BIT_SPACE: begin
            elapsed_next = elapsed_inc;
            end_space    = (elapsed_inc >= TOT_W'(cfg.space_us));
          end
          default: begin
            elapsed_next = elapsed;
          end
        endcase
        to_space    = end_mark && !space_zero;
        to_bit_mark = (end_mark && space_zero && phase == PH_HDR_MARK) ||
                      (end_space && phase == PH_HDR_SPACE);
        bit_done    = (end_mark && space_zero && phase == PH_BIT_MARK) ||
                      (end_space && phase == PH_BIT_SPACE);
        if (to_space) begin
          phase_next       = (phase == PH_HDR_MARK) ? PH_HDR_SPACE : PH_BIT_SPACE;
          elapsed_next     = '0;
          carrier_pos_next = '0;
        end else if (to_bit_mark) begin
          phase_next       = PH_BIT_MARK;
          elapsed_next     = '0;
          carrier_pos_next = '0;
        end else if (bit_done) begin
          elapsed_next     = '0;
          carrier_pos_next = '0;
          if (bits_left == '0) begin
            phase_next     = PH_IDLE;
            bit_shift_next = '0;
          end else begin
            phase_next     = PH_BIT_MARK;
            bits_left_next = bits_left - BITS_LEFT_W'(1);
            bit_shift_next = {bit_shift[FRAME_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_shift   <= '0;
      bits_left   <= '0;
      elapsed     <= '0;
      carrier_pos <= '0;
    end else begin
      phase       <= phase_next;
      bit_shift   <= bit_shift_next;
      bits_left   <= bits_left_next;
      elapsed     <= elapsed_next;
      carrier_pos <= carrier_pos_next;
    end
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (elapsed == '0 && carrier_pos == '0))
    else $error("idle with segment counters not cleared");

  a_start_frame: assert property (@(posedge clk) disable iff (rst)
    accept && action == ACT_SEND && phase == PH_IDLE |=> phase == PH_HDR_MARK)
    else $error("send while idle did not start a header mark");

endmodule
`default_nettype wire

@@ rtl/core/irtx_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irtx_out_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module irtx_out_buf (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  irtx_pkg::result_t  push_data,
  input  wire                out_stall,
  output logic               out_valid,
  output irtx_pkg::result_t  out_data,
  output logic               full
);
  import irtx_pkg::*;

  logic    skid_valid;
  result_t skid_data;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) out_data <= push_data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_skid_held: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid && $stable(skid_data))
    else $error("skid word lost under stall");

  a_push_kept: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && out_stall |=> skid_valid)
    else $error("word pushed into stalled output was dropped");

endmodule
`default_nettype wire

@@ rtl/core/ir_remote_frame_transmitter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ir_remote_frame_transmitter_top
// Infrared remote frame transmitter, one input word per microsecond.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): action 0 is a one-microsecond tick,
// action 1 starts a frame with code_word (ignored while a frame runs).
// Output channel (out_valid/out_stall): one word per input word, ir_level is
// the pin level for that microsecond, busy_res flags a frame in flight.
// Results are registered in the output buffer; throughput is one word per
// cycle while in_stall is low.
// A result register plus one skid entry lets one more input word in while
// the receiver stalls; with the skid entry full, in_stall is raised.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// carrier half period, header/zero/one mark lengths and the space length.
// After reset and after every config write, the burst length unit runs
// 12 remainder steps and one total update, rounding marks to whole carrier
// periods; in_stall is high and cfg_ready low during that time.
// Reset is synchronous and loads the default timings.
// ----------------------------------------------------------------------------
module ir_remote_frame_transmitter_top (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire                           action,
  input  wire [irtx_pkg::CODE_W-1:0]    code_word,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic                          ir_level,
  output logic                          busy_res,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [irtx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [irtx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irtx_pkg::*;

  cfg_t          cfg;
  burst_totals_t totals;
  result_t       res;
  result_t       out_data;
  logic          calc_busy;
  logic          buf_full;
  logic          accept;
  logic          cfg_write;

  assign cfg_ready = !calc_busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = buf_full || calc_busy || cfg_valid;
  assign accept    = in_valid && !in_stall;
  assign ir_level  = out_data.ir_level;
  assign busy_res  = out_data.busy_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.carrier_half_us <= RST_CARRIER_HALF;
      cfg.header_mark_us  <= RST_HEADER_MARK;
      cfg.zero_mark_us    <= RST_ZERO_MARK;
      cfg.one_mark_us     <= RST_ONE_MARK;
      cfg.space_us        <= RST_SPACE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CARRIER_HALF: cfg.carrier_half_us <= cfg_data[HALF_W-1:0];
        REG_HEADER_MARK:  cfg.header_mark_us  <= cfg_data[MARK_W-1:0];
        REG_ZERO_MARK:    cfg.zero_mark_us    <= cfg_data[MARK_W-1:0];
        REG_ONE_MARK:     cfg.one_mark_us     <= cfg_data[MARK_W-1:0];
        REG_SPACE:        cfg.space_us        <= cfg_data[MARK_W-1:0];
        default: begin
          cfg.space_us <= cfg.space_us;
        end
      endcase
    end
  end

  irtx_burst_calc u_burst_calc (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_write),
    .cfg    (cfg),
    .busy   (calc_busy),
    .totals (totals)
  );

  irtx_frame_engine u_frame_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .code_word (code_word),
    .cfg       (cfg),
    .totals    (totals),
    .res       (res)
  );

  irtx_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the infrared frame transmitter with microsecond ticks and send
// words. A cycle-true model of the frame sequencer predicts the pin level
// and busy flag of every word. Timing registers are reprogrammed between
// bursts, including while a frame is in flight, with random idle gaps on
// both channels.
// ----------------------------------------------------------------------------
module testbench;
  import irtx_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  action = ACT_TICK;
  logic [CODE_W-1:0]     code_word = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   in_stall;
  wire                   out_valid;
  wire                   ir_level;
  wire                   busy_res;
  wire                   cfg_ready;

  ir_remote_frame_transmitter_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .code_word (code_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ir_level  (ir_level),
    .busy_res  (busy_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // frame sequencer shadow
  cfg_t                   timing;
  phase_t                 tx_phase;
  logic [FRAME_BITS-1:0]  tx_shift;
  logic [BITS_LEFT_W-1:0] tx_bits_left;
  logic [TOT_W-1:0]       tx_elapsed;
  logic [PER_W-1:0]       tx_carrier_pos;

  result_t pending_pin_words[$];

  int src_gap_pct = 0;
  int sink_stall_pct = 0;
  int error_count = 0;
  int words_checked = 0;
  int frames_started = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    timing.carrier_half_us = RST_CARRIER_HALF;
    timing.header_mark_us  = RST_HEADER_MARK;
    timing.zero_mark_us    = RST_ZERO_MARK;
    timing.one_mark_us     = RST_ONE_MARK;
    timing.space_us        = RST_SPACE;
    tx_phase       = PH_IDLE;
    tx_shift       = '0;
    tx_bits_left   = '0;
    tx_elapsed     = '0;
    tx_carrier_pos = '0;
  end

  function automatic void start_segment(input phase_t ph);
    tx_phase       = ph;
    tx_elapsed     = '0;
    tx_carrier_pos = '0;
  endfunction

  function automatic void finish_bit();
    if (tx_bits_left == 0) begin
      start_segment(PH_IDLE);
      tx_shift = '0;
    end else begin
      tx_bits_left = tx_bits_left - 1'b1;
      tx_shift     = tx_shift << 1;
      start_segment(PH_BIT_MARK);
    end
  endfunction

  function automatic result_t next_pin_word(input logic act, input logic [CODE_W-1:0] code);
    result_t r;
    int      half;
    int      per;
    int      nominal;
    int      total;
    bit      in_header;
    r = '0;
    if (act == ACT_SEND) begin
      if (tx_phase == PH_IDLE) begin
        tx_shift     = FRAME_BITS'(code);
        tx_bits_left = BITS_LEFT_W'(FRAME_BITS - 1);
        start_segment(PH_HDR_MARK);
        frames_started++;
      end
      r.busy_res = 1'b1;
      return r;
    end
    if (tx_phase == PH_IDLE) return r;
    r.busy_res = 1'b1;
    half = (timing.carrier_half_us == 0) ? 1 : int'(timing.carrier_half_us);
    per  = 2 * half;
    in_header = (tx_phase == PH_HDR_MARK || tx_phase == PH_HDR_SPACE);
    if (tx_phase == PH_HDR_MARK || tx_phase == PH_BIT_MARK) begin
      if (int'(tx_carrier_pos) >= per) tx_carrier_pos = '0;
      r.ir_level = (int'(tx_carrier_pos) < half);
      if (in_header) nominal = int'(timing.header_mark_us);
      else if (tx_shift[FRAME_BITS-1]) nominal = int'(timing.one_mark_us);
      else nominal = int'(timing.zero_mark_us);
      total = (nominal / per + 1) * per;
      tx_carrier_pos = tx_carrier_pos + 1'b1;
      if (int'(tx_carrier_pos) >= per) tx_carrier_pos = '0;
      tx_elapsed = tx_elapsed + 1'b1;
      if (int'(tx_elapsed) >= total) begin
        if (timing.space_us != 0) begin
          if (in_header) start_segment(PH_HDR_SPACE);
          else start_segment(PH_BIT_SPACE);
        end else if (in_header) begin
          start_segment(PH_BIT_MARK);
        end else begin
          finish_bit();
        end
      end
    end else begin
      tx_elapsed = tx_elapsed + 1'b1;
      if (int'(tx_elapsed) >= int'(timing.space_us)) begin
        if (in_header) start_segment(PH_BIT_MARK);
        else finish_bit();
      end
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 50) $display("ERROR at %0t, word %0d: %s", $time, words_checked, msg);
    error_count++;
  endtask

  task automatic push_word(input logic act, input logic [CODE_W-1:0] code);
    while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    code_word <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pin_words.push_back(next_pin_word(act, code));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pin_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_CARRIER_HALF: timing.carrier_half_us = val[HALF_W-1:0];
      REG_HEADER_MARK:  timing.header_mark_us  = val[MARK_W-1:0];
      REG_ZERO_MARK:    timing.zero_mark_us    = val[MARK_W-1:0];
      REG_ONE_MARK:     timing.one_mark_us     = val[MARK_W-1:0];
      REG_SPACE:        timing.space_us        = val[MARK_W-1:0];
      default: ;
    endcase
    reg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [CFG_DATA_W-1:0] half, input logic [CFG_DATA_W-1:0] hdr,
                            input logic [CFG_DATA_W-1:0] zero, input logic [CFG_DATA_W-1:0] one,
                            input logic [CFG_DATA_W-1:0] gap);
    write_reg(REG_CARRIER_HALF, half, 1'b0);
    write_reg(REG_HEADER_MARK, hdr, 1'b0);
    write_reg(REG_ZERO_MARK, zero, 1'b0);
    write_reg(REG_ONE_MARK, one, 1'b0);
    write_reg(REG_SPACE, gap, 1'b1);
  endtask

  task automatic run_to_idle();
    while (tx_phase != PH_IDLE) push_word(ACT_TICK, CODE_W'($urandom));
  endtask

  task automatic test_idle_ticks();
    push_word(ACT_TICK, '0);
    push_word(ACT_TICK, '1);
  endtask

  // default timings, then retime mid header: segment ends, carrier wraps
  task automatic test_default_frame_retime();
    push_word(ACT_SEND, '1);
    repeat (40) push_word(ACT_TICK, CODE_W'($urandom));
    push_word(ACT_SEND, '0);
    repeat (10) push_word(ACT_TICK, CODE_W'($urandom));
    wait_drained();
    set_timing(12'd2, 12'd3, 12'd1, 12'd5, 12'd2);
    run_to_idle();
    push_word(ACT_TICK, '1);
  endtask

  task automatic test_zero_half_and_space();
    wait_drained();
    set_timing(12'h100, 12'd1, 12'd0, 12'd3, 12'd0);
    push_word(ACT_SEND, 20'hAAAAA);
    run_to_idle();
    wait_drained();
    write_reg(REG_SPACE, 12'd1, 1'b1);
    push_word(ACT_SEND, 20'h55555);
    run_to_idle();
  endtask

  task automatic test_unused_indexes();
    wait_drained();
    for (int r = int'(REG_SPACE) + 1; r < (1 << CFG_IDX_W); r++)
      write_reg(CFG_IDX_W'(r), '1, r == (1 << CFG_IDX_W) - 1);
    push_word(ACT_SEND, '1);
    run_to_idle();
  endtask

  task automatic test_extreme_timing();
    wait_drained();
    set_timing('1, '1, '0, '1, '1);
    push_word(ACT_SEND, 20'h80001);
    repeat (520) push_word(ACT_TICK, CODE_W'($urandom));
    wait_drained();
    set_timing(12'd1, 12'd0, 12'd0, 12'd0, 12'd0);
    run_to_idle();
  endtask

  task automatic test_random_traffic(input int n_words);
    logic act;
    for (int i = 0; i < n_words; i++) begin
      if (i % 25 == 0) begin
        wait_drained();
        if ($urandom_range(4) == 0)
          set_timing(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        else
          set_timing(CFG_DATA_W'($urandom_range(2)), CFG_DATA_W'($urandom_range(6)),
                     CFG_DATA_W'($urandom_range(6)), CFG_DATA_W'($urandom_range(6)),
                     CFG_DATA_W'($urandom_range(3)));
      end
      if (tx_phase == PH_IDLE) act = ($urandom_range(99) < 80) ? ACT_SEND : ACT_TICK;
      else act = ($urandom_range(99) < 4) ? ACT_SEND : ACT_TICK;
      push_word(act, CODE_W'($urandom));
    end
  endtask

  always @(posedge clk)
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pin_words.size() == 0) begin
        flag_error("output word with nothing expected");
      end else begin
        want = pending_pin_words.pop_front();
        if (ir_level !== want.ir_level)
          flag_error($sformatf("ir_level got %b want %b", ir_level, want.ir_level));
        if (busy_res !== want.busy_res)
          flag_error($sformatf("busy_res got %b want %b", busy_res, want.busy_res));
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("ir_remote_frame_transmitter_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    src_gap_pct    = 15;
    sink_stall_pct = 66;
    test_idle_ticks();
    test_default_frame_retime();
    test_zero_half_and_space();
    test_unused_indexes();
    test_extreme_timing();
    test_random_traffic(50);
    src_gap_pct    = 66;
    sink_stall_pct = 15;
    test_random_traffic(50);
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    test_random_traffic(50);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d output words over %0d frames started", words_checked, frames_started);
    $display("%0d register writes, %0d errors", reg_writes, error_count);
    if (error_count == 0)
      $display("ir_remote_frame_transmitter_top verification clean");
    else
      $display("ir_remote_frame_transmitter_top verification failed");
    $finish;
  end

endmodule
